### hdl/sct_pkg.sv
// Shared types and constants for the shell command tokenizer.
// Depends on nothing; used by sct_lexer, the top level and the checker.
package sct_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_CR,
    MODE_COMMENT,
    MODE_DOLLAR,
    MODE_SCAN,
    MODE_ALNUM,
    MODE_DIGITS,
    MODE_AMP,
    MODE_TEXT,
    MODE_REDIR1,
    MODE_REDIR2
  } mode_t;

  localparam logic [4:0] KIND_EOF      = 5'd0;
  localparam logic [4:0] KIND_EOL      = 5'd1;
  localparam logic [4:0] KIND_TEXT     = 5'd2;
  localparam logic [4:0] KIND_SETENV   = 5'd3;
  localparam logic [4:0] KIND_REDIRECT = 5'd4;
  localparam logic [4:0] KIND_ENVVAR   = 5'd5;
  localparam logic [4:0] KIND_INLINE   = 5'd6;
  localparam logic [4:0] KIND_ARG      = 5'd7;
  localparam logic [4:0] KIND_ERRNO    = 5'd8;
  localparam logic [4:0] KIND_ARGS     = 5'd9;
  localparam logic [4:0] KIND_DOT      = 5'd10;
  localparam logic [4:0] KIND_BANG     = 5'd11;
  localparam logic [4:0] KIND_AND      = 5'd12;
  localparam logic [4:0] KIND_OR       = 5'd13;
  localparam logic [4:0] KIND_SQUOTE   = 5'd14;
  localparam logic [4:0] KIND_DQUOTE   = 5'd15;
  localparam logic [4:0] KIND_IF       = 5'd16;
  localparam logic [4:0] KIND_THEN     = 5'd17;
  localparam logic [4:0] KIND_ELSE     = 5'd18;
  localparam logic [4:0] KIND_ELIF     = 5'd19;
  localparam logic [4:0] KIND_FI       = 5'd20;
  localparam logic [4:0] KIND_CASE     = 5'd21;
  localparam logic [4:0] KIND_ESAC     = 5'd22;
  localparam logic [4:0] KIND_FUNCTION = 5'd23;

  // Keyword spellings, first byte in the low byte.
  localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_THEN     = 64'h0000_0000_6E65_6874;
  localparam logic [63:0] KW_ELSE     = 64'h0000_0000_6573_6C65;
  localparam logic [63:0] KW_ELIF     = 64'h0000_0000_6669_6C65;
  localparam logic [63:0] KW_FI       = 64'h0000_0000_0000_6966;
  localparam logic [63:0] KW_CASE     = 64'h0000_0000_6573_6163;
  localparam logic [63:0] KW_ESAC     = 64'h0000_0000_6361_7365;
  localparam logic [63:0] KW_FUNCTION = 64'h6E6F_6974_636E_7566;

  localparam logic [15:0] PAREN_PAIR = 16'h2829;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] tbegin;
    logic [15:0] tend;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } res_t;

endpackage

### hdl/sct_if.sv
// Request channel interfaces of the shell command tokenizer.
// Depends on nothing.
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface sct_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_begin;
  logic [15:0] token_end;
  logic        last_of_run;
  modport source (output valid, token_kind, token_begin, token_end, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, token_begin, token_end, last_of_run,
                output ready);
endinterface

### hdl/sct_lexer.sv
// Lexer state registers and the single-pass next-state and token logic.
// Depends on sct_pkg.
module sct_lexer #(
  parameter int POS_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic            end_of_text,
  output sct_pkg::res_t   res
);

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    sct_pkg::mode_t mode;
    pos_t           span;
    logic [4:0]     pk;
    logic [7:0]     cc;
    logic [63:0]    pre;
    logic [3:0]     wl;
    logic           asg;
    logic [15:0]    l2;
    logic           fp;
    logic [1:0]     n;
    sct_pkg::tok_t  t0;
    sct_pkg::tok_t  t1;
  } st_t;

  st_t  st_r, st_nxt;
  pos_t pos_r, pos_nxt;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic st_t emit(st_t s, logic [4:0] k, pos_t b, pos_t e);
    sct_pkg::tok_t t;
    if (s.n == 2'd2) return s;
    if (s.fp) begin
      k = sct_pkg::KIND_FUNCTION;
      s.fp = 1'b0;
    end
    t.kind = k;
    t.tbegin = 16'(b);
    t.tend = 16'(e);
    t.last = 1'b0;
    if (s.n == 2'd0) s.t0 = t;
    else s.t1 = t;
    s.n = s.n + 2'd1;
    return s;
  endfunction

  function automatic st_t word_start(st_t s, pos_t b);
    s.span = b;
    s.pre = '0;
    s.wl = '0;
    s.asg = 1'b0;
    s.l2 = '0;
    s.mode = sct_pkg::MODE_TEXT;
    return s;
  endfunction

  function automatic st_t word_add(st_t s, logic [7:0] c);
    if (s.wl < 4'd8) s.pre[s.wl[2:0]*8 +: 8] = c;
    if (s.wl != 4'd15) s.wl = s.wl + 4'd1;
    s.l2 = {s.l2[7:0], c};
    return s;
  endfunction

  function automatic logic [4:0] kw_kind(st_t s);
    logic [4:0] k;
    k = sct_pkg::KIND_EOF;
    if (s.wl == 4'd2 && s.pre == sct_pkg::KW_IF) k = sct_pkg::KIND_IF;
    if (s.wl == 4'd4 && s.pre == sct_pkg::KW_THEN) k = sct_pkg::KIND_THEN;
    if (s.wl == 4'd4 && s.pre == sct_pkg::KW_ELSE) k = sct_pkg::KIND_ELSE;
    if (s.wl == 4'd4 && s.pre == sct_pkg::KW_ELIF) k = sct_pkg::KIND_ELIF;
    if (s.wl == 4'd2 && s.pre == sct_pkg::KW_FI) k = sct_pkg::KIND_FI;
    if (s.wl == 4'd4 && s.pre == sct_pkg::KW_CASE) k = sct_pkg::KIND_CASE;
    if (s.wl == 4'd4 && s.pre == sct_pkg::KW_ESAC) k = sct_pkg::KIND_ESAC;
    if (s.wl == 4'd8 && s.pre == sct_pkg::KW_FUNCTION) k = sct_pkg::KIND_FUNCTION;
    return k;
  endfunction

  function automatic st_t finish_text(st_t s, pos_t e);
    logic [4:0] k;
    s.mode = sct_pkg::MODE_IDLE;
    k = kw_kind(s);
    if (s.asg) s = emit(s, sct_pkg::KIND_SETENV, s.span, e);
    else if (k == sct_pkg::KIND_FUNCTION) s.fp = 1'b1;
    else if (k != sct_pkg::KIND_EOF) s = emit(s, k, s.span, e);
    else if (s.wl >= 4'd2 && s.l2 == sct_pkg::PAREN_PAIR)
      s = emit(s, sct_pkg::KIND_FUNCTION, s.span, e - pos_t'(2));
    else s = emit(s, sct_pkg::KIND_TEXT, s.span, e);
    return s;
  endfunction

  function automatic st_t idle_byte(st_t s, logic [7:0] c, pos_t p);
    s.mode = sct_pkg::MODE_IDLE;
    case (c)
      8'h0A, 8'h3B: s = emit(s, sct_pkg::KIND_EOL, p, p + pos_t'(1));
      8'h0D: begin
        s.span = p;
        s.mode = sct_pkg::MODE_CR;
      end
      8'h23: s.mode = sct_pkg::MODE_COMMENT;
      8'h24: begin
        s.span = p;
        s.mode = sct_pkg::MODE_DOLLAR;
      end
      8'h2E: s = emit(s, sct_pkg::KIND_DOT, p, p + pos_t'(1));
      8'h21: s = emit(s, sct_pkg::KIND_BANG, p, p + pos_t'(1));
      8'h3C, 8'h3E: s = emit(s, sct_pkg::KIND_REDIRECT, p, p + pos_t'(1));
      8'h26, 8'h7C: begin
        s.span = p;
        s.cc = c;
        s.mode = sct_pkg::MODE_AMP;
      end
      8'h27, 8'h22: begin
        s.pk = (c == 8'h27) ? sct_pkg::KIND_SQUOTE : sct_pkg::KIND_DQUOTE;
        s.cc = c;
        s.span = p + pos_t'(1);
        s.mode = sct_pkg::MODE_SCAN;
      end
      default: begin
        if (!is_space(c)) begin
          s = word_start(s, p);
          s = word_add(s, c);
        end
      end
    endcase
    return s;
  endfunction

  function automatic st_t text_byte(st_t s, logic [7:0] c, pos_t p);
    if (is_space(c)) begin
      s = finish_text(s, p);
      s = idle_byte(s, c, p);
    end else begin
      if (c == 8'h3D) s.asg = 1'b1;
      if (c == 8'h3E) s.mode = sct_pkg::MODE_REDIR1;
      else s = word_add(s, c);
    end
    return s;
  endfunction

  function automatic st_t step_byte(st_t s, logic [7:0] c, pos_t p);
    unique case (s.mode)
      sct_pkg::MODE_CR: begin
        if (c == 8'h0A) begin
          s.mode = sct_pkg::MODE_IDLE;
          s = emit(s, sct_pkg::KIND_EOL, p, p + pos_t'(1));
        end else begin
          s = emit(s, sct_pkg::KIND_EOL, s.span, s.span + pos_t'(1));
          s = idle_byte(s, c, p);
        end
      end
      sct_pkg::MODE_COMMENT: begin
        if (c == 8'h0A || c == 8'h0D) s = idle_byte(s, c, p);
      end
      sct_pkg::MODE_DOLLAR: begin
        if (c == 8'h28 || c == 8'h7B) begin
          s.pk = (c == 8'h28) ? sct_pkg::KIND_INLINE : sct_pkg::KIND_ENVVAR;
          s.cc = (c == 8'h28) ? 8'h29 : 8'h7D;
          s.span = p + pos_t'(1);
          s.mode = sct_pkg::MODE_SCAN;
        end else if (is_alpha(c)) begin
          s.pk = sct_pkg::KIND_ENVVAR;
          s.span = p;
          s.mode = sct_pkg::MODE_ALNUM;
        end else if (is_digit(c)) begin
          s.pk = sct_pkg::KIND_ARG;
          s.span = p;
          s.mode = sct_pkg::MODE_DIGITS;
        end else if (c == 8'h3F || c == 8'h2A) begin
          s.mode = sct_pkg::MODE_IDLE;
          s = emit(s, (c == 8'h3F) ? sct_pkg::KIND_ERRNO : sct_pkg::KIND_ARGS,
                   s.span, p + pos_t'(1));
        end else begin
          s = word_start(s, s.span);
          s = word_add(s, 8'h24);
          s = text_byte(s, c, p);
        end
      end
      sct_pkg::MODE_SCAN: begin
        if (c == s.cc) begin
          s.mode = sct_pkg::MODE_IDLE;
          s = emit(s, s.pk, s.span, p);
        end
      end
      sct_pkg::MODE_ALNUM, sct_pkg::MODE_DIGITS: begin
        if (!(is_digit(c) || (s.mode == sct_pkg::MODE_ALNUM && is_alpha(c)))) begin
          s = emit(s, s.pk, s.span, p);
          s = idle_byte(s, c, p);
        end
      end
      sct_pkg::MODE_AMP: begin
        if (c == s.cc) begin
          s.mode = sct_pkg::MODE_IDLE;
          s = emit(s, (s.cc == 8'h26) ? sct_pkg::KIND_AND : sct_pkg::KIND_OR,
                   s.span, p + pos_t'(1));
        end else begin
          s = word_start(s, s.span);
          s = word_add(s, s.cc);
          s = text_byte(s, c, p);
        end
      end
      sct_pkg::MODE_TEXT: s = text_byte(s, c, p);
      sct_pkg::MODE_REDIR1, sct_pkg::MODE_REDIR2: begin
        if (c == 8'h3E && s.mode == sct_pkg::MODE_REDIR1) begin
          s.mode = sct_pkg::MODE_REDIR2;
        end else begin
          s.mode = sct_pkg::MODE_IDLE;
          if (c == 8'h26) begin
            s = emit(s, sct_pkg::KIND_REDIRECT, s.span, p + pos_t'(1));
          end else begin
            s = emit(s, sct_pkg::KIND_REDIRECT, s.span, p);
            s = idle_byte(s, c, p);
          end
        end
      end
      default: s = idle_byte(s, c, p);
    endcase
    return s;
  endfunction

  function automatic st_t step_end(st_t s, pos_t p);
    unique case (s.mode)
      sct_pkg::MODE_CR: s = emit(s, sct_pkg::KIND_EOL, s.span, s.span + pos_t'(1));
      sct_pkg::MODE_SCAN, sct_pkg::MODE_ALNUM, sct_pkg::MODE_DIGITS:
        s = emit(s, s.pk, s.span, p);
      sct_pkg::MODE_AMP: begin
        s = word_start(s, s.span);
        s = word_add(s, s.cc);
        s = finish_text(s, p);
      end
      sct_pkg::MODE_TEXT: s = finish_text(s, p);
      sct_pkg::MODE_REDIR1, sct_pkg::MODE_REDIR2:
        s = emit(s, sct_pkg::KIND_REDIRECT, s.span, p);
      default: ;
    endcase
    s.mode = sct_pkg::MODE_IDLE;
    s = emit(s, sct_pkg::KIND_EOF, p, p);
    return s;
  endfunction

  always_comb begin
    st_t s;
    s = st_r;
    s.n = 2'd0;
    s.t0 = '0;
    s.t1 = '0;
    pos_nxt = pos_r;
    if (end_of_text) begin
      s = step_end(s, pos_r);
    end else begin
      s = step_byte(s, char_code, pos_r);
      pos_nxt = pos_r + pos_t'(1);
    end
    if (s.n == 2'd2) s.t1.last = 1'b1;
    else if (s.n == 2'd1) s.t0.last = 1'b1;
    st_nxt = s;
  end

  assign res.n  = accept ? st_nxt.n : 2'd0;
  assign res.t0 = st_nxt.t0;
  assign res.t1 = st_nxt.t1;

  // All-zero state is the between-tokens mode with every field cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      pos_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

### hdl/shell_command_tokenizer.sv
// Shell command tokenizer: one script byte per request in, tokens out.
// A token caused by a request is registered in the result queue and offered once the tokens ahead of it have left.
// Throughput: one request per cycle while the four-entry result queue has
// room for two tokens; a request's two tokens are buffered there and leave one at a time.
// Reset (rst_n low, synchronous) returns the lexer to between tokens, clears
// the byte position and empties the result queue. Depends on sct_pkg, sct_if, sct_lexer.
module shell_command_tokenizer #(
  parameter int POS_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  sct_in_if.sink         in_chan,
  sct_out_if.source      out_chan
);

  // The lexer updates its state on every accepted request and hands back up
  // to two tokens in the same cycle; those land in the result queue.
  sct_pkg::res_t res;
  logic          in_fire;
  logic          out_fire;

  sct_pkg::tok_t q_r [4];
  logic [1:0]    head_r, tail_r;
  logic [2:0]    cnt_r;

  // Room for the worst case of two tokens is required before a request is
  // taken, so the queue can never overflow.
  assign in_chan.ready = (cnt_r <= 3'd2);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  sct_lexer #(
    .POS_WIDTH (POS_WIDTH)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .char_code   (in_chan.char_code),
    .end_of_text (in_chan.end_of_text),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (res.n != 2'd0) q_r[tail_r] <= res.t0;
    if (res.n == 2'd2) q_r[tail_r + 2'd1] <= res.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + res.n;
      if (out_fire) head_r <= head_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, res.n} - {2'b00, out_fire};
    end
  end

  assign out_chan.valid       = (cnt_r != 3'd0);
  assign out_chan.token_kind  = q_r[head_r].kind;
  assign out_chan.token_begin = q_r[head_r].tbegin;
  assign out_chan.token_end   = q_r[head_r].tend;
  assign out_chan.last_of_run = q_r[head_r].last;

endmodule

### hdl/sct_checker.sv
// Port-level checks for the shell command tokenizer, bound to the top level.
// Depends on sct_pkg and shell_command_tokenizer.
module sct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_kind,
  input logic [15:0] out_begin,
  input logic [15:0] out_end,
  input logic        out_last
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_begin)
      && $stable(out_end) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sct_pkg::KIND_EOF |-> out_last)
    else $error("EOF token is not the final token of its request");

  a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sct_pkg::KIND_EOF |-> out_begin == out_end)
    else $error("EOF token has a non-empty span");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.token_kind),
  .out_begin (out_chan.token_begin),
  .out_end   (out_chan.token_end),
  .out_last  (out_chan.last_of_run)
);
